// File: src/gcpf_pkg.sv
// ----------------------------------------------------------------------------
// gcpf_pkg
// Shared codes, record types and the GP0 command length table of the
// GPU command port framer.
// ----------------------------------------------------------------------------
package gcpf_pkg;

	localparam logic [1:0] OP_GP0     = 2'd0;
	localparam logic [1:0] OP_GP1     = 2'd1;
	localparam logic [1:0] OP_GPUREAD = 2'd2;

	localparam logic [1:0] KIND_REG    = 2'd0;
	localparam logic [1:0] KIND_CMD    = 2'd1;
	localparam logic [1:0] KIND_IMAGE  = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_GP0  = 2'd1;
	localparam logic [1:0] ERR_BAD_INFO = 2'd2;
	localparam logic [1:0] ERR_BAD_GP1  = 2'd3;

	localparam logic [7:0] OPC_IMAGE   = 8'hA0;
	localparam logic [7:0] OPC_TEXWIN  = 8'hE2;
	localparam logic [7:0] OPC_AREA_TL = 8'hE3;
	localparam logic [7:0] OPC_AREA_BR = 8'hE4;
	localparam logic [7:0] OPC_OFFSET  = 8'hE5;
	localparam logic [7:0] OPC_MASK    = 8'hE6;

	localparam logic [7:0] GP1_RESET     = 8'h00;
	localparam logic [7:0] GP1_CMD_CLEAR = 8'h01;
	localparam logic [7:0] GP1_IRQ_ACK   = 8'h02;
	localparam logic [7:0] GP1_DISPLAY   = 8'h03;
	localparam logic [7:0] GP1_DMA       = 8'h04;
	localparam logic [7:0] GP1_DISP_START = 8'h05;
	localparam logic [7:0] GP1_HRANGE    = 8'h06;
	localparam logic [7:0] GP1_VRANGE    = 8'h07;
	localparam logic [7:0] GP1_MODE      = 8'h08;
	localparam logic [7:0] GP1_INFO      = 8'h10;

	localparam logic [23:0] INFO_AREA_TL = 24'd3;
	localparam logic [23:0] INFO_AREA_BR = 24'd4;
	localparam logic [23:0] INFO_OFFSET  = 24'd5;
	localparam logic [23:0] INFO_VERSION = 24'd7;
	localparam logic [31:0] GPU_VERSION  = 32'd2;

	typedef struct packed {
		logic clr_frame;
		logic clr_settings;
	} gcpf_gp1_cmd_t;

	typedef struct packed {
		logic [19:0] area_tl;
		logic [19:0] area_br;
		logic [21:0] offset;
	} gcpf_info_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] opcode;
		logic [3:0] index;
		logic       last;
		logic       image_last;
		logic [1:0] err;
	} gcpf_frame_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  kind;
		logic [1:0]  err;
	} gcpf_reg_t;

	typedef struct packed {
		logic       irq;
		logic       disp_off;
		logic [1:0] dma_dir;
	} gcpf_status_t;

	function automatic logic [3:0] cmd_len(input logic [7:0] opc);
		logic [3:0] len;
		case (opc) inside
			8'h00, 8'h01, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6: len = 4'd1;
			8'h68: len = 4'd2;
			8'h02, 8'h40, 8'h60, 8'h62, 8'h74, 8'h7D, 8'hA0, 8'hC0: len = 4'd3;
			8'h20, 8'h64, 8'h65, 8'h80: len = 4'd4;
			8'h28: len = 4'd5;
			8'h30: len = 4'd6;
			8'h38: len = 4'd8;
			8'h2C, 8'h2D, 8'h2F: len = 4'd9;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

// File: src/gcpf_framer.sv
// ----------------------------------------------------------------------------
// gcpf_framer
// Frames GP0 words into commands, counts image transfer words and latches
// the drawing settings carried by the E2 to E6 commands.
// ----------------------------------------------------------------------------
module gcpf_framer
	import gcpf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [1:0]    op,
	input  logic [31:0]   data,
	input  gcpf_gp1_cmd_t gp1,
	output gcpf_frame_t   frame,
	output gcpf_info_t    info
);

	logic [3:0]  words_q;
	logic [7:0]  cur_opc_q;
	logic        image_active_q;
	logic [30:0] image_left_q;
	logic [19:0] texwin_q;
	logic [19:0] area_tl_q;
	logic [19:0] area_br_q;
	logic [21:0] offset_q;
	logic [1:0]  mask_q;

	logic [7:0]  opc;
	logic [3:0]  len;
	logic        is_last;
	logic [31:0] px;
	logic [32:0] px_inc;
	logic [31:0] n_words;
	logic        gp0_fire;

	assign gp0_fire = fire && (op == OP_GP0);
	assign opc      = (words_q == 4'd0) ? data[31:24] : cur_opc_q;
	assign len      = cmd_len(opc);
	assign is_last  = ({1'b0, words_q} + 5'd1) >= {1'b0, len};
	assign px       = {16'd0, data[15:0]} * {16'd0, data[31:16]};
	assign px_inc   = {1'b0, px} + 33'd1;
	assign n_words  = px_inc[32:1];

	always_comb begin
		frame = '0;
		if (image_active_q) begin
			frame.kind       = KIND_IMAGE;
			frame.opcode     = OPC_IMAGE;
			frame.image_last = (image_left_q <= 31'd1);
		end else if (len == 4'd0) begin
			frame.kind   = KIND_REJECT;
			frame.err    = ERR_BAD_GP0;
			frame.opcode = opc;
		end else begin
			frame.kind   = KIND_CMD;
			frame.opcode = opc;
			frame.index  = words_q;
			frame.last   = is_last;
		end
	end

	assign info = '{area_tl: area_tl_q, area_br: area_br_q, offset: offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q        <= '0;
			cur_opc_q      <= '0;
			image_active_q <= 1'b0;
			image_left_q   <= '0;
			texwin_q       <= '0;
			area_tl_q      <= '0;
			area_br_q      <= '0;
			offset_q       <= '0;
			mask_q         <= '0;
		end else if (fire) begin
			if (gp1.clr_frame) begin
				words_q   <= '0;
				cur_opc_q <= '0;
			end
			if (gp1.clr_settings) begin
				texwin_q  <= '0;
				area_tl_q <= '0;
				area_br_q <= '0;
				offset_q  <= '0;
				mask_q    <= '0;
			end
			if (gp0_fire) begin
				if (image_active_q) begin
					if (image_left_q <= 31'd1) begin
						image_active_q <= 1'b0;
						image_left_q   <= '0;
					end else begin
						image_left_q <= image_left_q - 31'd1;
					end
				end else if (len != 4'd0) begin
					if (is_last) begin
						words_q   <= '0;
						cur_opc_q <= '0;
						case (opc)
							OPC_TEXWIN:  texwin_q  <= data[19:0];
							OPC_AREA_TL: area_tl_q <= data[19:0];
							OPC_AREA_BR: area_br_q <= data[19:0];
							OPC_OFFSET:  offset_q  <= data[21:0];
							OPC_MASK:    mask_q    <= data[1:0];
							OPC_IMAGE: begin
								if (n_words != 32'd0) begin
									image_active_q <= 1'b1;
									image_left_q   <= n_words[30:0];
								end
							end
							default: ;
						endcase
					end else begin
						words_q   <= words_q + 4'd1;
						cur_opc_q <= opc;
					end
				end
			end
		end
	end

	// The texture window and mask bits are kept as state; nothing reads them out.
	logic unused_settings;
	assign unused_settings = ^{texwin_q, mask_q};

	a_image_no_framing: assert property (@(posedge clk) disable iff (!arst_n)
		image_active_q |-> (words_q == 4'd0))
		else $error("Command framing open during an image transfer.");

	a_framing_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(words_q != 4'd0) |-> (words_q < cmd_len(cur_opc_q)))
		else $error("Word count exceeds the length of the open command.");

	a_image_count: assert property (@(posedge clk) disable iff (!arst_n)
		image_active_q |-> (image_left_q != 31'd0))
		else $error("Image transfer active with no words left.");

endmodule

// File: src/gcpf_ctrl.sv
// ----------------------------------------------------------------------------
// gcpf_ctrl
// Decodes GP1 words, holds the status, display and DMA settings and serves
// GPUREAD from the pending info word.
// ----------------------------------------------------------------------------
module gcpf_ctrl
	import gcpf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [1:0]    op,
	input  logic [31:0]   data,
	input  gcpf_info_t    info,
	output gcpf_gp1_cmd_t gp1,
	output gcpf_reg_t     reg_res,
	output gcpf_status_t  status
);

	logic         irq_q;
	logic         disp_off_q;
	logic [1:0]   dma_dir_q;
	logic [18:0]  disp_start_q;
	logic [43:0]  ranges_q;
	logic         read_pending_q;
	logic [31:0]  read_word_q;

	logic [7:0]   g;
	logic [23:0]  q;
	logic         info_hit;
	logic [31:0]  info_word;

	assign g = data[31:24];
	assign q = data[23:0];

	always_comb begin
		info_hit  = 1'b1;
		info_word = '0;
		unique case (q)
			INFO_AREA_TL: info_word = {12'd0, info.area_tl};
			INFO_AREA_BR: info_word = {12'd0, info.area_br};
			INFO_OFFSET:  info_word = {10'd0, info.offset};
			INFO_VERSION: info_word = GPU_VERSION;
			default:      info_hit  = 1'b0;
		endcase
	end

	always_comb begin
		gp1     = '0;
		reg_res = '{read_data: 32'd0, kind: KIND_REG, err: ERR_NONE};
		status  = '{irq: irq_q, disp_off: disp_off_q, dma_dir: dma_dir_q};
		unique case (op)
			OP_GP0: ;
			OP_GP1: begin
				unique case (g)
					GP1_RESET: begin
						gp1.clr_frame    = 1'b1;
						gp1.clr_settings = 1'b1;
						status           = '0;
					end
					GP1_CMD_CLEAR: gp1.clr_frame = 1'b1;
					GP1_IRQ_ACK:   status.irq = 1'b0;
					GP1_DISPLAY:   status.disp_off = data[0];
					GP1_DMA:       status.dma_dir = data[1:0];
					GP1_DISP_START, GP1_HRANGE, GP1_VRANGE, GP1_MODE: ;
					GP1_INFO: begin
						if (!info_hit) begin
							reg_res.kind = KIND_REJECT;
							reg_res.err  = ERR_BAD_INFO;
						end
					end
					default: begin
						reg_res.kind = KIND_REJECT;
						reg_res.err  = ERR_BAD_GP1;
					end
				endcase
			end
			OP_GPUREAD: reg_res.read_data = read_pending_q ? read_word_q : '1;
			default:    reg_res.kind = KIND_REJECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q          <= 1'b0;
			disp_off_q     <= 1'b0;
			dma_dir_q      <= '0;
			disp_start_q   <= '0;
			ranges_q       <= '0;
			read_pending_q <= 1'b0;
			read_word_q    <= '0;
		end else if (fire) begin
			irq_q      <= status.irq;
			disp_off_q <= status.disp_off;
			dma_dir_q  <= status.dma_dir;
			if (op == OP_GP1) begin
				case (g)
					GP1_RESET: begin
						disp_start_q <= '0;
						ranges_q     <= '0;
					end
					GP1_DISP_START: disp_start_q <= data[18:0];
					GP1_HRANGE:     ranges_q[23:0] <= data[23:0];
					GP1_VRANGE:     ranges_q[43:24] <= data[19:0];
					GP1_INFO: begin
						if (info_hit) begin
							read_word_q    <= info_word;
							read_pending_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end else if (op == OP_GPUREAD) begin
				read_pending_q <= 1'b0;
			end
		end
	end

	// Display start and ranges are kept as state; nothing reads them out.
	logic unused_display;
	assign unused_display = ^{disp_start_q, ranges_q};

	a_read_once: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (op == OP_GPUREAD)) |=> !read_pending_q)
		else $error("Pending info word survived a GPUREAD.");

endmodule

// File: src/gpu_command_port_framer_top.sv
// ----------------------------------------------------------------------------
// gpu_command_port_framer_top
// GP0/GP1/GPUREAD command port: input register, framing and register decode,
// result register.
// Timing: a word accepted into the input register loads its result into the
// result register once that register is empty or out_stall is low.
// Throughput: one word per cycle while out_stall is low; the input register and
// the result register let a new word enter while a finished result waits to be taken.
// Reset: arst_n clears framing, image count, settings, status and pending read.
// ----------------------------------------------------------------------------
module gpu_command_port_framer_top
	import gcpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [1:0]  word_kind,
	output logic [7:0]  cmd_opcode,
	output logic [3:0]  word_index,
	output logic        cmd_last,
	output logic        image_last,
	output logic [1:0]  error_code,
	output logic        irq_pending,
	output logic        display_disabled,
	output logic [1:0]  dma_direction
);

	logic          valid_s1;
	logic [1:0]    op_s1;
	logic [31:0]   data_s1;
	logic          valid_s2;
	logic          advance;
	logic          fire;
	logic          in_acc;

	gcpf_gp1_cmd_t gp1;
	gcpf_info_t    info;
	gcpf_frame_t   frame;
	gcpf_reg_t     reg_res;
	gcpf_status_t  status;
	gcpf_frame_t   res_frame;
	logic [31:0]   res_read;

	gcpf_frame_t   frame_s2;
	logic [31:0]   read_s2;
	gcpf_status_t  status_s2;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	gcpf_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.data   (data_s1),
		.gp1    (gp1),
		.frame  (frame),
		.info   (info)
	);

	gcpf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.op      (op_s1),
		.data    (data_s1),
		.info    (info),
		.gp1     (gp1),
		.reg_res (reg_res),
		.status  (status)
	);

	always_comb begin
		res_frame = '0;
		res_read  = reg_res.read_data;
		if (op_s1 == OP_GP0) begin
			res_frame = frame;
			res_read  = '0;
		end else begin
			res_frame.kind = reg_res.kind;
			res_frame.err  = reg_res.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op;
			data_s1 <= data;
		end
		if (fire) begin
			frame_s2  <= res_frame;
			read_s2   <= res_read;
			status_s2 <= status;
		end
	end

	assign out_valid        = valid_s2;
	assign read_data        = read_s2;
	assign word_kind        = frame_s2.kind;
	assign cmd_opcode       = frame_s2.opcode;
	assign word_index       = frame_s2.index;
	assign cmd_last         = frame_s2.last;
	assign image_last       = frame_s2.image_last;
	assign error_code       = frame_s2.err;
	assign irq_pending      = status_s2.irq;
	assign display_disabled = status_s2.disp_off;
	assign dma_direction    = status_s2.dma_dir;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("Input stalled without a held word.");

	a_image_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (word_kind == KIND_IMAGE)) |-> (cmd_opcode == OPC_IMAGE))
		else $error("Image data word carries a foreign opcode.");

	a_last_is_command: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cmd_last) |-> ((word_kind == KIND_CMD) && !image_last))
		else $error("Command end flagged on a word that is not a command word.");

endmodule
